@@ src/els_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package els_pkg;

   localparam int COORD_W         = 32;
   localparam int LEVEL_W         = 3;
   localparam int DIFF_W          = COORD_W + 1;
   localparam int PROD_W          = 2 * DIFF_W;
   localparam int CROSS_W         = PROD_W + 1;
   localparam int ABS_W           = PROD_W;
   localparam int HALF_W          = 32;
   localparam int HI_W            = ABS_W - HALF_W;
   localparam int SQ_W            = 131;
   localparam int CR_W            = SQ_W + 1;
   localparam int LSQ_W           = 2 * COORD_W;
   localparam int CHUNKS          = 5;
   localparam int ROW_W           = 164;
   localparam int NUM_W           = LSQ_W + CR_W;
   localparam int DEN_W           = PROD_W;
   localparam int QUO_W           = 64;
   localparam int FRAC_W          = 32;
   localparam int DIV_W           = DEN_W + FRAC_W;
   localparam int SAT_SHIFT       = QUO_W + FRAC_W;
   localparam int FRONT_STAGES    = 10;
   localparam int THRESHOLD_COUNT = 7;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [LEVEL_W-1:0]        level_type;

   localparam logic [QUO_W-1:0] LEVEL_LIMIT [THRESHOLD_COUNT] = '{
      64'd429497, 64'd214748365, 64'd730144440,
      64'h1_0000_0000, 64'h5_0000_0000, 64'h19_0000_0000, 64'h7D_0000_0000
   };

   typedef enum logic [2:0] {
      CSR_EYE_X        = 3'd0,
      CSR_EYE_Y        = 3'd1,
      CSR_EYE_Z        = 3'd2,
      CSR_LOD_FACTOR   = 3'd3,
      CSR_FORCED_LEVEL = 3'd4,
      CSR_MAX_LEVEL    = 3'd5
   } csr_index_type;

   typedef struct packed {
      coord_type          eye_x;
      coord_type          eye_y;
      coord_type          eye_z;
      logic [COORD_W-1:0] lod_factor;
      level_type          forced_level;
      level_type          max_level;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic             degen;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } front_out_type;

   typedef struct packed {
      logic             valid;
      logic             degen;
      logic             sat;
      logic [QUO_W-1:0] quo;
   } div_out_type;

endpackage
`default_nettype wire

@@ src/els_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface els_req_if;
   import els_pkg::*;
   logic      valid;
   logic      ready;
   coord_type start_x;
   coord_type start_y;
   coord_type start_z;
   coord_type end_x;
   coord_type end_y;
   coord_type end_z;
   coord_type mid_x;
   coord_type mid_y;
   coord_type mid_z;

   modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   mid_x, mid_y, mid_z, input ready);
   modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                 mid_x, mid_y, mid_z, output ready);
endinterface
`default_nettype wire

@@ src/els_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface els_rsp_if;
   import els_pkg::*;
   logic             valid;
   logic             ready;
   level_type        edge_level;
   logic [QUO_W-1:0] edge_error;
   logic             degenerate;

   modport source (output valid, edge_level, edge_error, degenerate, input ready);
   modport sink (input valid, edge_level, edge_error, degenerate, output ready);
endinterface
`default_nettype wire

@@ src/els_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module els_front (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  wire els_pkg::cfg_type cfg,
   els_req_if.sink             req,
   output els_pkg::front_out_type front_out
);
   import els_pkg::*;

   logic                      vld_ff   [FRONT_STAGES];
   logic                      degen_ff [FRONT_STAGES];

   logic signed [DIFF_W-1:0]  d_ff [3], q_ff [3], v_ff [3];
   logic signed [DIFF_W-1:0]  d_in [3], q_in [3], v_in [3];
   logic signed [PROD_W-1:0]  p_ff [6], vsq_ff [3];
   logic signed [CROSS_W-1:0] c_ff [3];
   logic [DEN_W-1:0]          den_ff [FRONT_STAGES];
   logic [ABS_W-1:0]          a_ff [3];
   logic [2*HI_W-1:0]         hh_ff [3];
   logic [ABS_W-1:0]          hl_ff [3];
   logic [2*HALF_W-1:0]       ll_ff [3];
   logic [SQ_W-1:0]           sq_ff [3];
   logic [CR_W-1:0]           cr_ff;
   logic [LSQ_W-1:0]          lsq_ff;
   logic [2*HALF_W-1:0]       pp_ff [2][CHUNKS];
   logic [ROW_W-1:0]          row_ff [2];
   logic [ROW_W-1:0]          row_in [2];
   logic [NUM_W-1:0]          num_ff;
   logic [CHUNKS*HALF_W-1:0]  cr_pad;
   logic                      degen_in;

   assign req.ready = advance;

   always_comb begin
      d_in[0] = {req.start_x[COORD_W-1], req.start_x} - {req.end_x[COORD_W-1], req.end_x};
      d_in[1] = {req.start_y[COORD_W-1], req.start_y} - {req.end_y[COORD_W-1], req.end_y};
      d_in[2] = {req.start_z[COORD_W-1], req.start_z} - {req.end_z[COORD_W-1], req.end_z};
      q_in[0] = {req.mid_x[COORD_W-1], req.mid_x} - {req.end_x[COORD_W-1], req.end_x};
      q_in[1] = {req.mid_y[COORD_W-1], req.mid_y} - {req.end_y[COORD_W-1], req.end_y};
      q_in[2] = {req.mid_z[COORD_W-1], req.mid_z} - {req.end_z[COORD_W-1], req.end_z};
      v_in[0] = {cfg.eye_x[COORD_W-1], cfg.eye_x} - {req.mid_x[COORD_W-1], req.mid_x};
      v_in[1] = {cfg.eye_y[COORD_W-1], cfg.eye_y} - {req.mid_y[COORD_W-1], req.mid_y};
      v_in[2] = {cfg.eye_z[COORD_W-1], cfg.eye_z} - {req.mid_z[COORD_W-1], req.mid_z};
      degen_in = ((d_in[0] == '0) && (d_in[1] == '0) && (d_in[2] == '0)) ||
                 ((v_in[0] == '0) && (v_in[1] == '0) && (v_in[2] == '0));
      cr_pad   = (CHUNKS*HALF_W)'(cr_ff);
      for (int j = 0; j < 2; j++) begin
         row_in[j] = '0;
         for (int k = 0; k < CHUNKS; k++) begin
            row_in[j] = row_in[j] + (ROW_W'(pp_ff[j][k]) << (HALF_W * k));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < FRONT_STAGES; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= req.valid;
         for (int s = 1; s < FRONT_STAGES; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         degen_ff[0] <= degen_in;
         den_ff[0]   <= '0;
         for (int s = 1; s < FRONT_STAGES; s++) begin
            degen_ff[s] <= degen_ff[s-1];
         end
         den_ff[1] <= den_ff[0];
         den_ff[2] <= DEN_W'($unsigned(vsq_ff[0])) + DEN_W'($unsigned(vsq_ff[1]))
                      + DEN_W'($unsigned(vsq_ff[2]));
         for (int s = 3; s < FRONT_STAGES; s++) begin
            den_ff[s] <= den_ff[s-1];
         end
         for (int i = 0; i < 3; i++) begin
            d_ff[i]   <= d_in[i];
            q_ff[i]   <= q_in[i];
            v_ff[i]   <= v_in[i];
            vsq_ff[i] <= PROD_W'(v_ff[i]) * PROD_W'(v_ff[i]);
            a_ff[i]   <= ABS_W'(c_ff[i][CROSS_W-1] ? -c_ff[i] : c_ff[i]);
            hh_ff[i]  <= (2*HI_W)'(a_ff[i][ABS_W-1:HALF_W])
                         * (2*HI_W)'(a_ff[i][ABS_W-1:HALF_W]);
            hl_ff[i]  <= ABS_W'(a_ff[i][ABS_W-1:HALF_W]) * ABS_W'(a_ff[i][HALF_W-1:0]);
            ll_ff[i]  <= (2*HALF_W)'(a_ff[i][HALF_W-1:0]) * (2*HALF_W)'(a_ff[i][HALF_W-1:0]);
            sq_ff[i]  <= (SQ_W'(hh_ff[i]) << (2*HALF_W)) + (SQ_W'(hl_ff[i]) << (HALF_W + 1))
                         + SQ_W'(ll_ff[i]);
         end
         p_ff[0] <= PROD_W'(d_ff[1]) * PROD_W'(q_ff[2]);
         p_ff[1] <= PROD_W'(d_ff[2]) * PROD_W'(q_ff[1]);
         p_ff[2] <= PROD_W'(d_ff[2]) * PROD_W'(q_ff[0]);
         p_ff[3] <= PROD_W'(d_ff[0]) * PROD_W'(q_ff[2]);
         p_ff[4] <= PROD_W'(d_ff[0]) * PROD_W'(q_ff[1]);
         p_ff[5] <= PROD_W'(d_ff[1]) * PROD_W'(q_ff[0]);
         c_ff[0] <= CROSS_W'(p_ff[0]) - CROSS_W'(p_ff[1]);
         c_ff[1] <= CROSS_W'(p_ff[2]) - CROSS_W'(p_ff[3]);
         c_ff[2] <= CROSS_W'(p_ff[4]) - CROSS_W'(p_ff[5]);
         cr_ff   <= CR_W'(sq_ff[0]) + CR_W'(sq_ff[1]) + CR_W'(sq_ff[2]);
         lsq_ff  <= LSQ_W'(cfg.lod_factor) * LSQ_W'(cfg.lod_factor);
         for (int j = 0; j < 2; j++) begin
            for (int k = 0; k < CHUNKS; k++) begin
               pp_ff[j][k] <= (2*HALF_W)'(lsq_ff[HALF_W*j +: HALF_W])
                              * (2*HALF_W)'(cr_pad[HALF_W*k +: HALF_W]);
            end
            row_ff[j] <= row_in[j];
         end
         num_ff <= NUM_W'(row_ff[0]) + (NUM_W'(row_ff[1]) << HALF_W);
      end
   end

   assign front_out.valid = vld_ff[FRONT_STAGES-1];
   assign front_out.degen = degen_ff[FRONT_STAGES-1];
   assign front_out.num   = num_ff;
   assign front_out.den   = den_ff[FRONT_STAGES-1];

endmodule
`default_nettype wire

@@ src/els_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module els_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire els_pkg::front_out_type front_out,
   output els_pkg::div_out_type       div_out
);
   import els_pkg::*;

   logic             vld_ff   [QUO_W+1];
   logic             degen_ff [QUO_W+1];
   logic             sat_ff   [QUO_W+1];
   logic [DIV_W-1:0] r_ff     [QUO_W+1];
   logic [QUO_W-1:0] low_ff   [QUO_W+1];
   logic [QUO_W-1:0] q_ff     [QUO_W+1];
   logic [DEN_W-1:0] den_ff   [QUO_W+1];

   logic [DIV_W:0]   trial [QUO_W];
   logic [DIV_W:0]   bdiv  [QUO_W];
   logic             ge    [QUO_W];
   logic             sat_in;

   always_comb begin
      sat_in = (front_out.num >> SAT_SHIFT) >= NUM_W'(front_out.den);
      for (int s = 0; s < QUO_W; s++) begin
         trial[s] = {r_ff[s], low_ff[s][QUO_W-1]};
         bdiv[s]  = {1'b0, den_ff[s], {FRAC_W{1'b0}}};
         ge[s]    = trial[s] >= bdiv[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QUO_W; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= front_out.valid;
         for (int s = 1; s <= QUO_W; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         degen_ff[0] <= front_out.degen;
         sat_ff[0]   <= sat_in;
         r_ff[0]     <= front_out.num[QUO_W +: DIV_W];
         low_ff[0]   <= front_out.num[QUO_W-1:0];
         q_ff[0]     <= '0;
         den_ff[0]   <= front_out.den;
         for (int s = 0; s < QUO_W; s++) begin
            degen_ff[s+1] <= degen_ff[s];
            sat_ff[s+1]   <= sat_ff[s];
            den_ff[s+1]   <= den_ff[s];
            low_ff[s+1]   <= low_ff[s] << 1;
            q_ff[s+1]     <= {q_ff[s][QUO_W-2:0], ge[s]};
            r_ff[s+1]     <= DIV_W'(ge[s] ? trial[s] - bdiv[s] : trial[s]);
         end
      end
   end

   assign div_out.valid = vld_ff[QUO_W];
   assign div_out.degen = degen_ff[QUO_W];
   assign div_out.sat   = sat_ff[QUO_W];
   assign div_out.quo   = q_ff[QUO_W];

endmodule
`default_nettype wire

@@ src/edge_screen_error_lod_select.sv @@
// channel | direction | payload
// req     | in        | start_x/y/z, end_x/y/z, mid_x/y/z (signed Q16.16)
// rsp     | out       | edge_level, edge_error (Q32.32), degenerate
// csr     | in        | csr_we, csr_index, csr_wdata (write only)
//
// One item per cycle while rsp is not stalled; 10 multiply/accumulate stages,
// one divider setup stage, 64 one-bit restoring divider stages, one level stage.
// Reset is synchronous, clears the valid bits and loads the configuration reset values.
// A stalled rsp freezes the whole pipeline; req.ready is low for that cycle.
`timescale 1ns / 1ps
`default_nettype none
module edge_screen_error_lod_select (
   input  wire logic        clock,
   input  wire logic        reset,
   els_req_if.sink          req,
   els_rsp_if.source        rsp,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import els_pkg::*;

   cfg_type          cfg_ff;
   logic             advance;
   front_out_type    front_out;
   div_out_type      div_out;

   logic             rsp_valid_ff;
   level_type        level_ff, level_in;
   logic [QUO_W-1:0] error_ff, error_in;
   logic             degen_ff;
   logic [7:0]       gt;
   level_type        start_level;

   assign advance = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.eye_x        <= '0;
         cfg_ff.eye_y        <= '0;
         cfg_ff.eye_z        <= '0;
         cfg_ff.lod_factor   <= 32'd655;
         cfg_ff.forced_level <= '0;
         cfg_ff.max_level    <= 3'd7;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EYE_X:        cfg_ff.eye_x        <= csr_wdata;
            CSR_EYE_Y:        cfg_ff.eye_y        <= csr_wdata;
            CSR_EYE_Z:        cfg_ff.eye_z        <= csr_wdata;
            CSR_LOD_FACTOR:   cfg_ff.lod_factor   <= csr_wdata;
            CSR_FORCED_LEVEL: cfg_ff.forced_level <= csr_wdata[LEVEL_W-1:0];
            CSR_MAX_LEVEL:    cfg_ff.max_level    <= csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   els_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .req       (req),
      .front_out (front_out)
   );

   els_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .front_out (front_out),
      .div_out   (div_out)
   );

   always_comb begin
      error_in = (div_out.degen || div_out.sat) ? '1 : div_out.quo;
      gt = '0;
      for (int i = 0; i < THRESHOLD_COUNT; i++) begin
         gt[i] = LEVEL_LIMIT[i] < error_in;
      end
      start_level = (cfg_ff.forced_level > cfg_ff.max_level) ? cfg_ff.max_level
                                                             : cfg_ff.forced_level;
      level_in = start_level;
      for (int i = 0; i < THRESHOLD_COUNT; i++) begin
         if ((level_in < cfg_ff.max_level) && (level_in < LEVEL_W'(THRESHOLD_COUNT))
             && gt[level_in]) begin
            level_in = level_in + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         level_ff <= level_in;
         error_ff <= error_in;
         degen_ff <= div_out.degen;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.edge_level = level_ff;
   assign rsp.edge_error = error_ff;
   assign rsp.degenerate = degen_ff;

   a_degen_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.degenerate |-> rsp.edge_error == '1)
      else $error("degenerate item without saturated error");

   a_stall_holds_div: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(div_out))
      else $error("divider moved during stall");

   a_zero_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.edge_error == '0) |-> rsp.edge_level == start_level)
      else $error("level raised on zero error");

endmodule
`default_nettype wire

@@ bench/tb_edge_screen_error_lod_select.sv @@
`timescale 1ns / 1ps
module tb_edge_screen_error_lod_select;
   import els_pkg::*;

   localparam logic [2:0] CSR_UNUSED = 3'd6;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 100;
   localparam int PHASE_ITEMS = 90;

   typedef struct packed {
      coord_type start_x, start_y, start_z;
      coord_type end_x, end_y, end_z;
      coord_type mid_x, mid_y, mid_z;
   } edge_item;

   typedef struct packed {
      level_type   lvl;
      logic [63:0] err;
      logic        dg;
   } edge_result;

   typedef struct packed {
      edge_item   it;
      logic       has_exp;
      edge_result res;
   } edge_entry;

   logic clock;
   logic reset;
   logic csr_we;
   logic [2:0] csr_index;
   logic [31:0] csr_wdata;

   els_req_if req_ch ();
   els_rsp_if rsp_ch ();

   edge_screen_error_lod_select uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   coord_type   eye_x_q, eye_y_q, eye_z_q;
   logic [31:0] lod_q;
   level_type   forced_q, max_q;

   edge_entry  edge_queue[$];
   edge_result error_queue[$];
   edge_entry  cur_edge;
   int send_idle_pct;
   int recv_stall_pct;
   int fail_count;
   int idle_cycles;
   int hold_left;
   bit long_hold_req;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic edge_result predict_edge(edge_item it);
      logic signed [255:0] sx, sy, sz, ex, ey, ez, mx, my, mz;
      logic signed [255:0] dx, dy, dz, qx, qy, qz, vx, vy, vz;
      logic signed [255:0] c0, c1, c2, cr, den, num;
      logic [255:0] lsq, quo;
      edge_result r;
      sx = 256'(it.start_x); sy = 256'(it.start_y); sz = 256'(it.start_z);
      ex = 256'(it.end_x);   ey = 256'(it.end_y);   ez = 256'(it.end_z);
      mx = 256'(it.mid_x);   my = 256'(it.mid_y);   mz = 256'(it.mid_z);
      dx = sx - ex; dy = sy - ey; dz = sz - ez;
      qx = mx - ex; qy = my - ey; qz = mz - ez;
      vx = 256'(eye_x_q); vy = 256'(eye_y_q); vz = 256'(eye_z_q);
      vx = vx - mx; vy = vy - my; vz = vz - mz;
      den = vx * vx + vy * vy + vz * vz;
      r.dg = (dx == 0 && dy == 0 && dz == 0) || den == 0;
      if (r.dg) begin
         r.err = '1;
      end else begin
         c0 = dy * qz - dz * qy;
         c1 = dz * qx - dx * qz;
         c2 = dx * qy - dy * qx;
         cr = c0 * c0 + c1 * c1 + c2 * c2;
         lsq = {224'b0, lod_q};
         num = lsq * lsq * $unsigned(cr);
         quo = $unsigned(num) / $unsigned(den);
         if (quo[255:96] != 0) r.err = '1;
         else r.err = quo[95:32];
      end
      r.lvl = (forced_q > max_q) ? max_q : forced_q;
      while (r.lvl < max_q && r.lvl < 7 && LEVEL_LIMIT[r.lvl] < r.err)
         r.lvl = r.lvl + 1'b1;
      return r;
   endfunction

   function automatic coord_type near_coord(coord_type base, int bits);
      coord_type off;
      off = $signed($urandom) >>> (31 - bits);
      return base + off;
   endfunction

   function automatic edge_item random_edge();
      edge_item it;
      int kind;
      int bits;
      coord_type bx, by, bz;
      kind = $urandom_range(0, 99);
      bits = $urandom_range(2, 30);
      bx = $urandom; by = $urandom; bz = $urandom;
      if (kind < 20) begin
         it = {$urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
      end else begin
         it.start_x = near_coord(bx, bits);
         it.start_y = near_coord(by, bits);
         it.start_z = near_coord(bz, bits);
         it.end_x = near_coord(bx, bits);
         it.end_y = near_coord(by, bits);
         it.end_z = near_coord(bz, bits);
         it.mid_x = near_coord(bx, bits);
         it.mid_y = near_coord(by, bits);
         it.mid_z = near_coord(bz, bits);
         if (kind < 85) begin
         end else if (kind < 90) begin
            it.mid_x = it.start_x; it.mid_y = it.start_y; it.mid_z = it.start_z;
         end else if (kind < 95) begin
            it.end_x = it.start_x; it.end_y = it.start_y; it.end_z = it.start_z;
         end else begin
            it.mid_x = eye_x_q; it.mid_y = eye_y_q; it.mid_z = eye_z_q;
         end
      end
      return it;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_EYE_X:        eye_x_q = data;
         CSR_EYE_Y:        eye_y_q = data;
         CSR_EYE_Z:        eye_z_q = data;
         CSR_LOD_FACTOR:   lod_q = data;
         CSR_FORCED_LEVEL: forced_q = data[2:0];
         CSR_MAX_LEVEL:    max_q = data[2:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (edge_queue.size() != 0 || req_ch.valid || error_queue.size() != 0)
         @(posedge clock);
   endtask

   task automatic load_config(input logic [31:0] ex, input logic [31:0] ey,
                              input logic [31:0] ez, input logic [31:0] lf,
                              input logic [2:0] fl, input logic [2:0] ml);
      write_reg(CSR_EYE_X, ex);
      write_reg(CSR_EYE_Y, ey);
      write_reg(CSR_EYE_Z, ez);
      write_reg(CSR_LOD_FACTOR, lf);
      write_reg(CSR_FORCED_LEVEL, {29'b0, fl});
      write_reg(CSR_MAX_LEVEL, {29'b0, ml});
      csr_we <= 1'b0;
   endtask

   task automatic push_random(input int count);
      edge_entry e;
      for (int i = 0; i < count; i++) begin
         e.it = random_edge();
         e.has_exp = 1'b0;
         e.res = '0;
         edge_queue.push_back(e);
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            if (cur_edge.has_exp) error_queue.push_back(cur_edge.res);
            else error_queue.push_back(predict_edge(cur_edge.it));
         end
         if (edge_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            cur_edge = edge_queue.pop_front();
            req_ch.start_x <= cur_edge.it.start_x;
            req_ch.start_y <= cur_edge.it.start_y;
            req_ch.start_z <= cur_edge.it.start_z;
            req_ch.end_x <= cur_edge.it.end_x;
            req_ch.end_y <= cur_edge.it.end_y;
            req_ch.end_z <= cur_edge.it.end_z;
            req_ch.mid_x <= cur_edge.it.mid_x;
            req_ch.mid_y <= cur_edge.it.mid_y;
            req_ch.mid_z <= cur_edge.it.mid_z;
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      edge_result want;
      if (rsp_ch.valid && rsp_ch.ready && !reset) begin
         if (error_queue.size() == 0) begin
            $error("unexpected item: level %0d error %h degenerate %b",
                   rsp_ch.edge_level, rsp_ch.edge_error, rsp_ch.degenerate);
            fail_count++;
         end else begin
            want = error_queue.pop_front();
            if (rsp_ch.edge_level !== want.lvl) begin
               $error("edge_level: expected %0d actual %0d", want.lvl, rsp_ch.edge_level);
               fail_count++;
            end
            if (rsp_ch.edge_error !== want.err) begin
               $error("edge_error: expected %h actual %h", want.err, rsp_ch.edge_error);
               fail_count++;
            end
            if (rsp_ch.degenerate !== want.dg) begin
               $error("degenerate: expected %b actual %b", want.dg, rsp_ch.degenerate);
               fail_count++;
            end
         end
      end
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else if (error_queue.size() != 0 || edge_queue.size() != 0)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   edge_entry directed [] = '{
      '{'{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 32'h0002_0000,
          32'h0003_0000, 32'h0005_0000, 32'h0000_0000, 32'h0000_0000},
        1'b1, '{3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1}},
      '{'{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        1'b1, '{3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1}},
      '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
        1'b0, '0},
      '{'{32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0002_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000},
        1'b1, '{3'd0, 64'h0, 1'b0}},
      '{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF},
        1'b0, '0},
      '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
        1'b0, '0},
      '{'{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0000_8000, 32'h0000_0001, 32'h0100_0000},
        1'b0, '0},
      '{'{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0000_8000, 32'h0000_1000, 32'h0001_0000},
        1'b0, '0},
      '{'{32'h0010_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0008_0000, 32'h0002_0000, 32'h0004_0000},
        1'b0, '0},
      '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002},
        1'b0, '0},
      '{'{32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000},
        1'b0, '0},
      '{'{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h5555_5555,
          32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC, 32'h0000_0001},
        1'b0, '0}
   };

   initial begin
      logic [31:0] ex, ey, ez;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_EYE_X;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.start_x = '0; req_ch.start_y = '0; req_ch.start_z = '0;
      req_ch.end_x = '0; req_ch.end_y = '0; req_ch.end_z = '0;
      req_ch.mid_x = '0; req_ch.mid_y = '0; req_ch.mid_z = '0;
      rsp_ch.ready = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fail_count = 0;
      idle_cycles = 0;
      hold_left = 0;
      long_hold_req = 1'b0;
      eye_x_q = '0; eye_y_q = '0; eye_z_q = '0;
      lod_q = 32'd655; forced_q = '0; max_q = 3'd7;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) edge_queue.push_back(directed[i]);
      wait_drained();

      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      csr_we <= 1'b0;
      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         repeat (80) @(posedge clock);
         ex = $urandom; ey = $urandom; ez = $urandom;
         case (ph)
            0: load_config(ex, ey, ez, 32'h0001_0000, 3'd0, 3'd7);
            1: load_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'hFFFF_FFFF, 3'd7, 3'd3);
            2: load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h0000_0000, 3'd2, 3'd7);
            3: load_config(32'h0, 32'h0, 32'h0, 32'h0000_0001, 3'd0, 3'd0);
            4: load_config(ex, ey, ez, $urandom, 3'($urandom), 3'($urandom));
            default: load_config(ex >>> 12, ey >>> 12, ez >>> 12, 32'd655, 3'd5, 3'd7);
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         if (ph == 0) long_hold_req = 1'b1;
         push_random(PHASE_ITEMS / 2);
         wait_drained();
         push_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
